// ===== sv/lts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lts_pkg;

    localparam int KEY_W   = 64;
    localparam int INDEX_W = 4;

    typedef logic [KEY_W-1:0]   t_key;
    typedef logic [INDEX_W-1:0] t_index;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

endpackage

`default_nettype wire

// ===== sv/lts_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface lts_req_if
    import lts_pkg::*;
();
    logic valid;
    logic ready;
    logic cmd;
    t_key key;

    modport source (output valid, output cmd, output key, input ready);
    modport sink   (input valid, input cmd, input key, output ready);
endinterface

interface lts_rsp_if
    import lts_pkg::*;
();
    logic   valid;
    logic   ready;
    logic   hit;
    t_index line_index;
    logic   evicted;

    modport source (output valid, output hit, output line_index, output evicted, input ready);
    modport sink   (input valid, input hit, input line_index, input evicted, output ready);
endinterface

`default_nettype wire

// ===== sv/lru_tag_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Direction | Payload
// i_req    | in        | cmd, key
// o_rsp    | out       | hit, line_index, evicted
//
// An item is registered on acceptance and resolved against the line state once the output
// register is free; that cycle's closing edge loads its result into the output register. Unless
// the output stalls, one item per cycle is sustained, as state updates land before the next item is resolved.
// Reset clears all lines to invalid and the stamp counter to zero; no clearing pass is needed.
// A stalled result holds the output register; the input register keeps accepting until it
// is also occupied.
// Recency is kept as a pairwise age matrix that mirrors the order of the stamps.

module lru_tag_store
    import lts_pkg::*;
#(
    parameter int LINES      = 10,
    parameter int KEY_BITS   = 64,
    parameter int STAMP_BITS = 32
) (
    input  wire     i_clk,
    input  wire     i_rst_n,
    lts_req_if.sink   i_req,
    lts_rsp_if.source o_rsp
);

    localparam int LINE_W = (LINES > 1) ? $clog2(LINES) : 1;
    localparam logic [STAMP_BITS-1:0] STAMP_MAX = {STAMP_BITS{1'b1}};

    logic                  r_in_valid;
    logic                  r_cmd;
    logic [KEY_BITS-1:0]   r_key;

    logic [LINES-1:0]      r_valid;
    logic [KEY_BITS-1:0]   r_keys [LINES];
    logic [LINES-1:0]      r_sat;
    logic [LINES-1:0]      r_older [LINES];
    logic [STAMP_BITS-1:0] r_top;

    logic                  r_out_valid;
    logic                  r_hit;
    t_index                r_idx;
    logic                  r_evicted;

    logic                  w_out_free;
    logic                  w_go;
    logic [LINES-1:0]      w_match;
    logic                  w_any_match;
    logic [LINE_W-1:0]     w_match_idx;
    logic                  w_any_free;
    logic [LINE_W-1:0]     w_free_idx;
    logic [LINES-1:0]      w_lru_oh;
    logic [LINE_W-1:0]     w_lru_idx;
    logic                  w_stamp_en;
    logic [LINE_W-1:0]     w_line;
    logic [STAMP_BITS-1:0] n_top;
    logic                  w_new_sat;
    logic                  w_hit;
    logic                  w_evicted;

    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_go        = r_in_valid && w_out_free;
    assign i_req.ready = !r_in_valid || w_out_free;

    always_comb begin
        w_match     = '0;
        w_match_idx = '0;
        w_free_idx  = '0;
        w_lru_idx   = '0;
        for (int i = 0; i < LINES; i++) begin
            w_match[i]  = r_valid[i] && (r_keys[i] == r_key);
            w_lru_oh[i] = 1'b1;
            for (int j = 0; j < LINES; j++) begin
                if (j != i) begin
                    w_lru_oh[i] = w_lru_oh[i] && r_older[i][j];
                end
            end
        end
        for (int i = LINES - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_match_idx = LINE_W'(i);
            end
            if (!r_valid[i]) begin
                w_free_idx = LINE_W'(i);
            end
        end
        for (int i = 0; i < LINES; i++) begin
            if (w_lru_oh[i]) begin
                w_lru_idx = w_lru_idx | LINE_W'(i);
            end
        end
        w_any_match = |w_match;
        w_any_free  = !(&r_valid);
    end

    always_comb begin
        n_top     = (r_top == STAMP_MAX) ? r_top : r_top + 1'b1;
        w_new_sat = (n_top == STAMP_MAX);
        if (r_cmd == CMD_INSERT) begin
            w_hit      = 1'b0;
            w_evicted  = !w_any_free;
            w_line     = w_any_free ? w_free_idx : w_lru_idx;
            w_stamp_en = w_go;
        end else begin
            w_hit      = w_any_match;
            w_evicted  = 1'b0;
            w_line     = w_any_match ? w_match_idx : '0;
            w_stamp_en = w_go && w_any_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
        if (i_req.valid && i_req.ready) begin
            r_cmd <= i_req.cmd;
            r_key <= i_req.key[KEY_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_sat   <= '0;
            r_top   <= '0;
            for (int i = 0; i < LINES; i++) begin
                for (int j = 0; j < LINES; j++) begin
                    r_older[i][j] <= (i < j);
                end
            end
        end else if (w_stamp_en) begin
            r_top <= n_top;
            for (int i = 0; i < LINES; i++) begin
                if (w_line == LINE_W'(i)) begin
                    r_sat[i] <= w_new_sat;
                    if (r_cmd == CMD_INSERT) begin
                        r_valid[i] <= 1'b1;
                    end
                end
                for (int j = 0; j < LINES; j++) begin
                    if (i != j && w_line == LINE_W'(i)) begin
                        r_older[i][j] <= w_new_sat && r_sat[j] && (i < j);
                    end else if (i != j && w_line == LINE_W'(j)) begin
                        r_older[i][j] <= !(w_new_sat && r_sat[i] && (j < i));
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && r_cmd == CMD_INSERT) begin
            r_keys[w_line] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
        if (w_go) begin
            r_hit     <= w_hit;
            r_idx     <= INDEX_W'(w_line);
            r_evicted <= w_evicted;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.hit        = r_hit;
    assign o_rsp.line_index = r_idx;
    assign o_rsp.evicted    = r_evicted;

`ifndef SYNTHESIS
    a_lru_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_valid) |-> $onehot(w_lru_oh))
        else $error("Age matrix does not give a single oldest line.");

    a_hit_not_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_hit && r_evicted))
        else $error("A result reports both a hit and an eviction.");

    a_top_monotone: assert property (@(posedge i_clk)
        (i_rst_n && $past(i_rst_n)) |-> (r_top >= $past(r_top)))
        else $error("Stamp counter moved backward.");

    a_stamp_on_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_top != $past(r_top)) |-> $past(w_go))
        else $error("Stamp counter advanced without an item in process.");
`endif

endmodule

`default_nettype wire
